@@ design/stw_pkg.sv @@
// Shared types, constants and register codes for the swing time warp block.
`timescale 1ns / 1ps

package stw_pkg;

  localparam int SEG_DEPTH_DEF = 65536;
  localparam int LEN_MAX       = 65536;

  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 17;
  localparam int POS_W    = 16;
  localparam int RATIO_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // quotient bits of the long division: integer part plus 16 fraction bits
  localparam int QUOT_W = 33;
  localparam int CNT_W  = $clog2(QUOT_W + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_RATIO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_SWING   = 2'd2;

  localparam logic [LEN_W-1:0]   RST_SEGMENT_LENGTH = 17'd24000;
  localparam logic [RATIO_W-1:0] RST_SPLIT_RATIO    = 16'd43691;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_RD0,
    ST_RD1,
    ST_MAC,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic setup;
    logic second;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_step;
    logic rd0;
    logic rd1;
    logic mac;
    logic sum;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic start_prev;
    logic ends_beat;
    logic endpoint;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ design/stw_ctrl.sv @@
// Sequencer for the swing time warp block: one item and its results at a time.
`timescale 1ns / 1ps

module stw_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  stw_pkg::status_t st,
  output stw_pkg::cmd_t   cmd,
  output stw_pkg::state_t state
);

  stw_pkg::state_t state_next;
  logic second;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= stw_pkg::ST_IDLE;
      second <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        second <= 1'b0;
      end else if (cmd.emit && !second && st.ends_beat) begin
        second <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      stw_pkg::ST_IDLE: begin
        if (in_valid && st.start_prev) state_next = stw_pkg::ST_SETUP;
      end
      stw_pkg::ST_SETUP: state_next = stw_pkg::ST_MUL1;
      stw_pkg::ST_MUL1: begin
        state_next = st.endpoint ? stw_pkg::ST_RD0 : stw_pkg::ST_MUL2;
      end
      stw_pkg::ST_MUL2: state_next = stw_pkg::ST_MUL3;
      stw_pkg::ST_MUL3: state_next = stw_pkg::ST_DIV;
      stw_pkg::ST_DIV: begin
        if (st.div_last) state_next = stw_pkg::ST_RD0;
      end
      stw_pkg::ST_RD0: state_next = stw_pkg::ST_RD1;
      stw_pkg::ST_RD1: state_next = stw_pkg::ST_MAC;
      stw_pkg::ST_MAC: state_next = stw_pkg::ST_SUM;
      stw_pkg::ST_SUM: state_next = stw_pkg::ST_EMIT;
      stw_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_next = (!second && st.ends_beat) ? stw_pkg::ST_SETUP : stw_pkg::ST_IDLE;
        end
      end
      default: state_next = stw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.second = second;
    in_ready   = 1'b0;
    case (state)
      stw_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      stw_pkg::ST_SETUP: cmd.setup    = 1'b1;
      stw_pkg::ST_MUL1:  cmd.mul1     = 1'b1;
      stw_pkg::ST_MUL2:  cmd.mul2     = 1'b1;
      stw_pkg::ST_MUL3:  cmd.mul3     = 1'b1;
      stw_pkg::ST_DIV:   cmd.div_step = 1'b1;
      stw_pkg::ST_RD0:   cmd.rd0      = 1'b1;
      stw_pkg::ST_RD1:   cmd.rd1      = 1'b1;
      stw_pkg::ST_MAC:   cmd.mac      = 1'b1;
      stw_pkg::ST_SUM:   cmd.sum      = 1'b1;
      stw_pkg::ST_EMIT:  cmd.emit     = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ design/stw_datapath.sv @@
// Datapath: config registers, beat store, warp arithmetic, divider and output register.
`timescale 1ns / 1ps

module stw_datapath #(
  parameter int SEG_DEPTH = stw_pkg::SEG_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [stw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [stw_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic signed [stw_pkg::SAMPLE_W-1:0]   sample_in,
  input  stw_pkg::cmd_t                         cmd,
  output stw_pkg::status_t                      st,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic signed [stw_pkg::SAMPLE_W-1:0]   sample_out,
  output logic                                  segment_end
);

  localparam int ADDR_W  = $clog2(SEG_DEPTH);
  localparam int LEN_CAP = (SEG_DEPTH < stw_pkg::LEN_MAX) ? SEG_DEPTH : stw_pkg::LEN_MAX;
  localparam logic [stw_pkg::LEN_W-1:0] CAP = stw_pkg::LEN_W'(LEN_CAP);

  localparam int SW = stw_pkg::SAMPLE_W;
  localparam int PW = stw_pkg::POS_W;
  localparam int LW = stw_pkg::LEN_W;
  localparam int QW = stw_pkg::QUOT_W;

  // config
  logic [LW-1:0]                 segment_length;
  logic [stw_pkg::RATIO_W-1:0]   split_ratio;
  logic                          remove_swing;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_length <= stw_pkg::RST_SEGMENT_LENGTH;
      split_ratio    <= stw_pkg::RST_SPLIT_RATIO;
      remove_swing   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        stw_pkg::CFG_SEGMENT_LENGTH: segment_length <= cfg_data;
        stw_pkg::CFG_SPLIT_RATIO:    split_ratio    <= cfg_data[15:0];
        stw_pkg::CFG_REMOVE_SWING:   remove_swing   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective length, position and ratio
  logic [LW-1:0] len_eff;
  logic [PW-1:0] lenm1_eff;
  logic [PW-1:0] beat_position;
  logic [PW-1:0] pos_cl;
  logic [PW-1:0] ratio_nz;
  logic [PW-1:0] u16_eff;

  always_comb begin
    len_eff = segment_length;
    if (segment_length < LW'(2)) len_eff = LW'(2);
    else if (segment_length > CAP) len_eff = CAP;
    lenm1_eff = PW'(len_eff - LW'(1));
    pos_cl    = ({1'b0, beat_position} >= len_eff) ? lenm1_eff : beat_position;
    ratio_nz  = (split_ratio == '0) ? PW'(1) : split_ratio;
    u16_eff   = remove_swing ? PW'(17'h10000 - {1'b0, ratio_nz}) : ratio_nz;
  end

  // per-item latches
  logic [LW-1:0] len;
  logic [PW-1:0] lenm1;
  logic [PW-1:0] u16;
  logic [PW-1:0] pos;
  logic          ends_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_position <= '0;
    end else if (cmd.accept) begin
      beat_position <= (pos_cl == lenm1_eff) ? '0 : PW'(pos_cl + PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      len       <= len_eff;
      lenm1     <= lenm1_eff;
      u16       <= u16_eff;
      pos       <= pos_cl;
      ends_beat <= (pos_cl == lenm1_eff);
    end
  end

  // beat store
  logic signed [SW-1:0] mem [SEG_DEPTH];
  logic signed [SW-1:0] rdata;
  logic [PW-1:0]        rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[ADDR_W'(pos_cl)] <= sample_in;
    end
    if (cmd.rd0 || cmd.rd1) begin
      rdata <= mem[ADDR_W'(rd_idx)];
    end
  end

  // warp position and products
  logic [PW-1:0]   idx;
  logic            endpoint;
  logic [31:0]     p_ul;
  logic [LW+PW-1:0] p_li;
  logic [31:0]     p_lc;
  logic            case1;
  logic [32:0]     n_mid;
  logic [32:0]     dvs;
  logic [49:0]     n_val;
  logic [PW-1:0]   one_minus_u;

  assign endpoint    = (idx == '0) || (idx >= lenm1);
  assign one_minus_u = PW'(17'h10000 - {1'b0, u16});
  assign n_val       = case1 ? {2'b0, p_li, 15'b0} : 50'(len * n_mid);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      idx <= cmd.second ? lenm1 : PW'(pos - PW'(1));
    end
    if (cmd.mul1) begin
      p_ul <= u16 * lenm1;
      p_li <= len * idx;
      p_lc <= lenm1 * one_minus_u;
    end
    if (cmd.mul2) begin
      case1 <= ({idx, 16'b0} <= p_ul);
      n_mid <= {(LW'(lenm1) + LW'(idx)), 16'b0} - {p_ul, 1'b0};
      dvs   <= ({idx, 16'b0} <= p_ul) ? {1'b0, p_ul} : {p_lc, 1'b0};
    end
  end

  // restoring divider: quotient holds integer part and 16 fraction bits
  logic [QW-1:0]          rem;
  logic [QW-1:0]          low;
  logic [QW-1:0]          quot;
  logic [stw_pkg::CNT_W-1:0] cnt;
  logic [QW:0]            trial;
  logic                   ge;

  assign trial = {rem, low[QW-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.mul3) begin
      cnt <= stw_pkg::CNT_W'(QW);
    end else if (cmd.div_step) begin
      cnt <= cnt - stw_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul3) begin
      rem  <= n_val[49:17];
      low  <= {n_val[16:0], 16'b0};
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? QW'(trial - {1'b0, dvs}) : trial[QW-1:0];
      low  <= {low[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

  // sample indexes and weight
  logic [PW-1:0] idx0;
  logic [PW-1:0] idx1;
  logic [PW-1:0] wgt;

  always_comb begin
    if (endpoint) begin
      idx0 = idx;
      wgt  = '0;
    end else begin
      idx0 = (quot[QW-1:16] > {1'b0, lenm1}) ? lenm1 : quot[PW+15:16];
      wgt  = quot[15:0];
    end
    idx1   = (idx0 >= lenm1) ? lenm1 : PW'(idx0 + PW'(1));
    rd_idx = cmd.rd1 ? idx1 : idx0;
  end

  // interpolation
  logic signed [SW-1:0] x0;
  logic signed [40:0]   prod0;
  logic signed [40:0]   prod1;
  logic signed [41:0]   acc;
  logic signed [25:0]   vsh;
  logic signed [SW-1:0] res;
  logic [PW:0]          wgt_c;

  assign wgt_c = 17'h10000 - {1'b0, wgt};
  assign acc   = 42'(prod0) + 42'(prod1) + 42'sd32768;
  assign vsh   = acc[41:16];

  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      x0 <= rdata;
    end
    if (cmd.mac) begin
      prod0 <= 41'(x0 * $signed({1'b0, wgt_c}));
      prod1 <= 41'(rdata * $signed({1'b0, wgt}));
    end
    if (cmd.sum) begin
      if (vsh > 26'sd8388607) res <= 24'sh7FFFFF;
      else if (vsh < -26'sd8388608) res <= 24'sh800000;
      else res <= vsh[SW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out  <= res;
      segment_end <= cmd.second;
    end
  end

  always_comb begin
    st.start_prev = (pos_cl != '0);
    st.ends_beat  = ends_beat;
    st.endpoint   = endpoint;
    st.div_last   = (cnt == stw_pkg::CNT_W'(1));
    st.out_free   = !out_valid || out_ready;
  end

endmodule

@@ design/swing_time_warp_top.sv @@
// Top level of the swing time warp block: stream ports, config port, controller and datapath.
//
//  channel  | signals                                  | direction
//  s_axis   | s_axis_tvalid/tready, tdata[23:0]         | in:  sample_in
//  m_axis   | m_axis_tvalid/tready, tdata[23:0], tlast  | out: sample_out, segment_end
//  cfg      | cfg_valid/ready, cfg_index[1:0], cfg_data | in:  register writes
//
// One item at a time. An item at beat position 0 is only accepted and stored; any other item
// is accepted, then its result goes through setup, the multiply steps, the radix-2 divider,
// read, multiply-accumulate, sum and emit, or skips the later multiply steps and the divide
// when it is a beat endpoint. The last item of a beat then adds its endpoint result.
// Reset clears the config to defaults and the beat position; the beat store is not cleared.
// A stalled output holds the controller in its emit state; the next item waits for it.
`timescale 1ns / 1ps

module swing_time_warp_top #(
  parameter int SEG_DEPTH = stw_pkg::SEG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] sample_out
  output logic        m_axis_tlast,   // segment_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [stw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stw_pkg::CFG_DATA_W-1:0] cfg_data
);

  stw_pkg::cmd_t    cmd;
  stw_pkg::status_t st;
  stw_pkg::state_t  state;
  logic signed [stw_pkg::SAMPLE_W-1:0] sample_out;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = sample_out;

  stw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd),
    .state    (state)
  );

  stw_datapath #(
    .SEG_DEPTH (SEG_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_in   (s_axis_tdata),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .sample_out  (sample_out),
    .segment_end (m_axis_tlast)
  );

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !s_axis_tready)
    else $error("input accepted while divider runs");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_axis_tvalid)
    else $error("emitted result not presented");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == stw_pkg::ST_SETUP) || s_axis_tready)
    else $error("controller lost track after item accept");

  a_second_last: assert property (@(posedge clk) disable iff (rst)
    (state == stw_pkg::ST_DIV) |-> !st.out_free || m_axis_tvalid || !cmd.emit)
    else $error("emit during divide");

endmodule

@@ tb/tb_swing_time_warp_top.sv @@
// Self-checking regression for the swing time warp block: directed and random beats vs. a bit-exact predictor.
`timescale 1ns / 1ps

module tb_swing_time_warp_top;
  import stw_pkg::*;

  // watchdog limit: several times over the slowest correct run, stalls included
  localparam int unsigned WATCHDOG_CYCLES = 1000000;
  localparam int unsigned SETTLE_CYCLES   = 120;
  localparam int unsigned HOLD_CYCLES     = 1500;
  localparam int unsigned ITEM_TARGET     = 1300;
  localparam int unsigned HALF_U          = 32768;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [4] =
    '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                seg_end;
  } warp_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]   m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 55;
  logic        hold_req = 1'b0;
  logic        hold_active = 1'b0;

  // predictor state
  logic [LEN_W-1:0]          shadow_len = RST_SEGMENT_LENGTH;
  logic [RATIO_W-1:0]        shadow_ratio = RST_SPLIT_RATIO;
  logic                      shadow_remove = 1'b0;
  int unsigned               beat_pos = 0;
  logic signed [SAMPLE_W-1:0] beat_mem [SEG_DEPTH_DEF];
  bit                        written [SEG_DEPTH_DEF];
  warp_result_t              pending_warps [$];

  int unsigned samples_taken = 0;
  int unsigned results_seen = 0;
  int unsigned beats_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  swing_time_warp_top DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_warps.size());
      $display("swing_time_warp_top regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned usable_length(input logic [LEN_W-1:0] len_reg);
    longint unsigned l;
    l = len_reg;
    if (l < 2) l = 2;
    if (l > LEN_MAX) l = LEN_MAX;
    if (l > SEG_DEPTH_DEF) l = SEG_DEPTH_DEF;
    return l;
  endfunction

  function automatic longint unsigned warp_ratio(input logic [RATIO_W-1:0] ratio,
                                                 input logic remove);
    longint unsigned r;
    r = (ratio == 0) ? 1 : ratio;
    return remove ? 65536 - r : r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] warped_sample(input longint unsigned i,
                                                        input longint unsigned len);
    longint unsigned u16, n, d, q, w, i0, i1;
    longint x0, x1, acc, v;
    u16 = warp_ratio(shadow_ratio, shadow_remove);
    if (i == 0) return beat_mem[0];
    if (i >= len - 1) return beat_mem[len - 1];
    if (i * 65536 <= u16 * (len - 1)) begin
      n = len * i * 32768;
      d = (len - 1) * u16;
    end else begin
      n = len * (65536 * (len - 1 + i) - 2 * u16 * (len - 1));
      d = 2 * (len - 1) * (65536 - u16);
    end
    q = n / d;
    w = ((n % d) << 16) / d;
    i0 = (q > len - 1) ? len - 1 : q;
    i1 = (q + 1 > len - 1) ? len - 1 : q + 1;
    x0 = beat_mem[i0];
    x1 = beat_mem[i1];
    acc = x0 * longint'(65536 - w) + x1 * longint'(w) + 32768;
    v = acc >>> 16;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[SAMPLE_W-1:0];
  endfunction

  // input and config side of the predictor
  always @(posedge clk) begin
    longint unsigned len, p;
    if (rst) begin
      shadow_len = RST_SEGMENT_LENGTH;
      shadow_ratio = RST_SPLIT_RATIO;
      shadow_remove = 1'b0;
      beat_pos = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_SEGMENT_LENGTH: shadow_len = cfg_data[LEN_W-1:0];
          CFG_SPLIT_RATIO:    shadow_ratio = cfg_data[RATIO_W-1:0];
          CFG_REMOVE_SWING:   shadow_remove = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        samples_taken++;
        len = usable_length(shadow_len);
        p = beat_pos;
        if (p >= len) p = len - 1;
        beat_mem[p] = s_axis_tdata;
        written[p] = 1'b1;
        if (p > 0)
          pending_warps.insert(pending_warps.size(),
                               warp_result_t'{warped_sample(p - 1, len), 1'b0});
        if (p == len - 1) begin
          pending_warps.insert(pending_warps.size(),
                               warp_result_t'{warped_sample(len - 1, len), 1'b1});
          beat_pos = 0;
        end else begin
          beat_pos = p + 1;
        end
      end
    end
  end

  function automatic void note_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                        input logic [SAMPLE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %h got %h", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    warp_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tlast) beats_seen++;
      if (pending_warps.size() == 0) begin
        note_mismatch("unexpected item", '0, m_axis_tdata);
      end else begin
        want = pending_warps.pop_front();
        if (m_axis_tdata !== want.sample) note_mismatch("sample_out", want.sample, m_axis_tdata);
        if (m_axis_tlast !== want.seg_end)
          note_mismatch("segment_end", 24'(want.seg_end), 24'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk)
    m_axis_tready <= !hold_active && ($urandom_range(0, 99) >= recv_idle_pct);

  initial begin : receiver_hold
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
      hold_req = 1'b0;
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    if ($urandom_range(0, 9) == 0) return EDGE_SAMPLES[$urandom_range(0, 3)];
    return SAMPLE_W'($urandom);
  endfunction

  function automatic int unsigned beat_remaining(input longint unsigned eff);
    return int'(eff - ((beat_pos >= eff) ? eff - 1 : beat_pos));
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_warps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // unused upper data bits carry noise; the block must ignore them
  task automatic configure(input logic [LEN_W-1:0] len_reg, input logic [RATIO_W-1:0] ratio,
                           input logic remove, input bit spare);
    drain();
    cfg_write(CFG_SEGMENT_LENGTH, len_reg);
    cfg_write(CFG_SPLIT_RATIO, {1'($urandom), ratio});
    cfg_write(CFG_REMOVE_SWING, {16'($urandom), remove});
    if (spare) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    for (int k = 0; k < 5; k++) send_sample(EDGE_SAMPLES[k % 4]);
  endtask

  // shrink mid-beat, then the shortest beat with the ratio-zero and remove cases
  task automatic test_length_clamps();
    configure(17'd3, RST_SPLIT_RATIO, 1'b0, 1'b0);
    for (int k = 0; k < 4; k++) send_sample(EDGE_SAMPLES[(k + 1) % 4]);
    configure(17'd0, 16'd0, 1'b1, 1'b1);
    send_sample(EDGE_SAMPLES[0]);
    send_sample(EDGE_SAMPLES[1]);
  endtask

  task automatic test_length_max();
    configure(17'h1FFFF, 16'hFFFF, 1'b0, 1'b0);
    repeat (4) send_sample(random_sample());
    configure(17'h10000, 16'h8000, 1'b1, 1'b0);
    repeat (2) send_sample(random_sample());
  endtask

  // tiny split points read far ahead of the samples received so far
  task automatic test_swing_extremes();
    configure(17'd5, 16'd1, 1'b0, 1'b0);
    repeat (beat_remaining(5)) send_sample(random_sample());
    configure(17'd7, 16'd32767, 1'b0, 1'b0);
    repeat (7) send_sample(random_sample());
  endtask

  task automatic test_output_backpressure();
    int unsigned n;
    configure(17'd6, 16'd21845, 1'b0, 1'b0);
    n = beat_remaining(6) + 12;
    hold_req = 1'b1;
    repeat (n) send_sample(random_sample());
  endtask

  task automatic test_random_beats(input int unsigned until_items);
    logic [LEN_W-1:0]   len_reg;
    logic [RATIO_W-1:0] ratio;
    logic               remove;
    bit                 filled;
    longint unsigned    eff;
    int unsigned        n, pick;
    while (samples_taken < until_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len_reg = LEN_W'($urandom_range(2, 16));
      else if (pick < 85) len_reg = LEN_W'($urandom_range(17, 64));
      else if (pick < 95) len_reg = LEN_W'($urandom_range(65, 300));
      else if (pick < 97) len_reg = LEN_W'($urandom_range(0, 1));
      else len_reg = LEN_W'($urandom_range(1000, 131071));
      case ($urandom_range(0, 9))
        0: ratio = 16'd0;
        1: ratio = 16'd1;
        2: ratio = 16'hFFFF;
        3: ratio = 16'h8000;
        default: ratio = RATIO_W'($urandom);
      endcase
      remove = 1'($urandom);
      eff = usable_length(len_reg);
      // a split below one half reads ahead; only allowed once the whole beat range holds data
      filled = 1'b1;
      for (int a = 0; a < eff; a++) if (!written[a]) filled = 1'b0;
      if (!filled && warp_ratio(ratio, remove) < HALF_U) remove = !remove;
      if (eff > 300) begin
        n = $urandom_range(1, 8);
      end else begin
        n = beat_remaining(eff) + int'(eff) * $urandom_range(0, (eff <= 16) ? 3 : 1);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      end
      if (n > until_items - samples_taken) n = until_items - samples_taken;
      configure(len_reg, ratio, remove, 1'b0);
      repeat (n) send_sample(random_sample());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 55;
    test_reset_defaults();
    test_length_clamps();
    test_length_max();
    test_swing_extremes();
    test_output_backpressure();
    test_random_beats(ITEM_TARGET / 3);

    send_idle_pct = 55;
    recv_idle_pct = 16;
    test_random_beats(2 * ITEM_TARGET / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_beats(ITEM_TARGET);

    drain();
    $display("covered %0d samples and %0d results over %0d beats, %0d register writes",
             samples_taken, results_seen, beats_seen, reg_writes);
    $display("beat lengths 2 to 65536, both swing directions, a %0d-cycle output hold, %0d bad",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && pending_warps.size() == 0) begin
      $display("swing_time_warp_top regression: pass");
    end else begin
      $display("swing_time_warp_top regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/stw_pkg.sv
design/stw_ctrl.sv
design/stw_datapath.sv
design/swing_time_warp_top.sv
tb/tb_swing_time_warp_top.sv
